### sv/cham_pkg.sv
package cham_pkg;

    localparam int Rounds = 80;

    // four 32-bit words, word 0 in the lowest bits
    typedef logic [3:0][31:0] block_t;
    typedef logic [7:0][31:0] rk_t;

    // configuration register indexes
    localparam logic RegKeyLow  = 1'b0;
    localparam logic RegKeyHigh = 1'b1;

    function automatic logic [31:0] rol1(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [31:0] rol8(input logic [31:0] v);
        return {v[23:0], v[31:24]};
    endfunction

    function automatic logic [31:0] rol11(input logic [31:0] v);
        return {v[20:0], v[31:21]};
    endfunction

    // one arx round; only word r mod 4 changes
    function automatic block_t cham_round(input block_t x, input logic [6:0] r,
                                          input logic [31:0] rk);
        logic [1:0]  w;
        logic [1:0]  nx;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
        block_t      y;
        w  = r[1:0];
        nx = w + 2'd1;
        y  = x;
        a  = x[w] ^ {25'd0, r};
        if (r[0] == 1'b0)
        begin
            b    = rol1(x[nx]) ^ rk;
            sum  = a + b;
            y[w] = rol8(sum);
        end
        else
        begin
            b    = rol8(x[nx]) ^ rk;
            sum  = a + b;
            y[w] = rol1(sum);
        end
        return y;
    endfunction

endpackage

### sv/cham128_block_encrypt_unit.sv
// CHAM-128/128 encryption, fully unrolled: each of the 80 rounds is one
// register stage holding a single 32-bit add, so a block can be accepted
// every cycle while the pipeline is not frozen; its ciphertext passes
// through the 80 round stages and then the output register. A skid slot
// behind the output register keeps taking blocks while a result waits;
// the pipeline freezes only once that slot is full. Round keys are derived
// combinationally from the key registers, so a key write applies to every
// block accepted afterward; write the key only while no block is in flight.
module cham128_block_encrypt_unit
    import cham_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic         wr_index,
    input  logic [63:0]  wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // plaintext_low, plaintext_high
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // ciphertext_low, ciphertext_high
);

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    rk_t         rk;
    logic        pipe_en;
    logic        skid_valid;
    block_t      out_data;

    logic        stage_valid [0:Rounds];
    block_t      stage_data  [0:Rounds];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                RegKeyLow:  key_low_reg  <= wr_data;
                RegKeyHigh: key_high_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    cham_key_sched u_key_sched (
        .key_low  (key_low_reg),
        .key_high (key_high_reg),
        .rk       (rk)
    );

    assign stage_valid[0] = s_tvalid;
    assign stage_data[0]  = s_tdata;

    for (genvar g = 0; g < Rounds; g++)
    begin : g_round
        localparam logic [2:0] RkIdx = 3'(g % 8);

        cham_round_stage #(
            .Round (g)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .rk        (rk[RkIdx]),
            .valid_reg (stage_valid[g + 1]),
            .data_reg  (stage_data[g + 1])
        );
    end

    cham_out_buf u_out_buf (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (stage_valid[Rounds]),
        .in_data        (stage_data[Rounds]),
        .en             (pipe_en),
        .out_valid_reg  (m_tvalid),
        .out_data_reg   (out_data),
        .out_ready      (m_tready),
        .skid_valid_reg (skid_valid)
    );

    assign s_tready = pipe_en;
    assign m_tdata  = out_data;

    // skid slot is only used behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid |-> m_tvalid)
        else $error("skid slot full without a pending result");

    // a drained skid slot refills the output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid && m_tready |=> m_tvalid && !skid_valid)
        else $error("skid beat lost on drain");

    // frozen pipeline holds its last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(stage_valid[Rounds]))
        else $error("last stage moved while stalled");

endmodule

### sv/cham_key_sched.sv
module cham_key_sched
    import cham_pkg::*;
(
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    output rk_t         rk
);

    logic [3:0][31:0] kw;

    assign kw = {key_high, key_low};

    always_comb
    begin
        rk = '0;
        for (int i = 0; i < 4; i++)
        begin
            rk[3'(i)]           = kw[2'(i)] ^ rol1(kw[2'(i)]) ^ rol8(kw[2'(i)]);
            // second half of the schedule swaps neighbors
            rk[3'((i + 4) ^ 1)] = kw[2'(i)] ^ rol1(kw[2'(i)]) ^ rol11(kw[2'(i)]);
        end
    end

endmodule

### sv/cham_round_stage.sv
module cham_round_stage
    import cham_pkg::*;
#(
    parameter int Round = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  block_t      in_data,
    input  logic [31:0] rk,
    output logic        valid_reg,
    output block_t      data_reg
);

    localparam logic [6:0] RoundNum = 7'(Round);

    block_t data_next;

    assign data_next = cham_round(in_data, RoundNum, rk);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### sv/cham_out_buf.sv
module cham_out_buf
    import cham_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  block_t in_data,
    output logic   en,
    output logic   out_valid_reg,
    output block_t out_data_reg,
    input  logic   out_ready,
    output logic   skid_valid_reg
);

    block_t skid_data_reg;
    logic   take;

    // pipeline only moves while the skid slot is free
    assign en   = !skid_valid_reg;
    assign take = en && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (take)
            begin
                out_data_reg <= in_data;
            end
        end
        else if (take)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

### test/tb.sv
module tb
    import cham_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {ReadyAlways, ReadyRandom, ReadyLongStall} ready_mode_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         wr_en = 1'b0;
    logic         wr_index = RegKeyLow;
    logic [63:0]  wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // plaintext_low, plaintext_high
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // ciphertext_low, ciphertext_high

    logic [127:0] plain_q[$];
    logic [127:0] cipher_q[$];
    logic [63:0]  key_lo_copy;
    logic [63:0]  key_hi_copy;
    int           mismatches = 0;

    int           max_gap = 0;
    int           gap_left = 0;
    int           burst_left = 1;
    ready_mode_t  ready_mode = ReadyAlways;
    int           stall_left = 0;

    cham128_block_encrypt_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] cham_encrypt(input logic [63:0] key_lo,
                                                  input logic [63:0] key_hi,
                                                  input logic [127:0] plain);
        logic [31:0] kw[4];
        logic [31:0] rk[8];
        logic [31:0] x[4];
        logic [31:0] mixed;
        logic [31:0] sum;
        int          w;
        int          nx;
        kw[0] = key_lo[31:0];
        kw[1] = key_lo[63:32];
        kw[2] = key_hi[31:0];
        kw[3] = key_hi[63:32];
        for (int i = 0; i < 4; i++)
        begin
            rk[i]           = kw[i] ^ rotl(kw[i], 1) ^ rotl(kw[i], 8);
            rk[(i + 4) ^ 1] = kw[i] ^ rotl(kw[i], 1) ^ rotl(kw[i], 11);
        end
        for (int i = 0; i < 4; i++)
            x[i] = plain[32*i +: 32];
        for (int r = 0; r < Rounds; r++)
        begin
            w  = r % 4;
            nx = (r + 1) % 4;
            // even rounds feed rol1 of the neighbor and rotate the sum by 8, odd ones swap
            mixed = rotl(x[nx], (r % 2 == 0) ? 1 : 8) ^ rk[r % 8];
            sum   = (x[w] ^ 32'(r)) + mixed;
            x[w]  = rotl(sum, (r % 2 == 0) ? 8 : 1);
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            gap_left   <= 0;
            burst_left <= 1;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (plain_q.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= plain_q.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            case (ready_mode)
                ReadyAlways:
                    m_tready <= 1'b1;
                ReadyRandom:
                    m_tready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (stall_left != 0)
                    begin
                        stall_left <= stall_left - 1;
                        m_tready   <= 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left <= $urandom_range(1, 40);
                        m_tready   <= 1'b0;
                    end
                    else
                    begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // key tracking, prediction at input beat, check at output beat
    always @(posedge clk or negedge rst_n)
    begin
        logic [127:0] want;
        if (!rst_n)
        begin
            key_lo_copy <= '0;
            key_hi_copy <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    RegKeyLow:  key_lo_copy <= wr_data;
                    RegKeyHigh: key_hi_copy <= wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                cipher_q.push_back(cham_encrypt(key_lo_copy, key_hi_copy, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (cipher_q.size() == 0)
                begin
                    $error("unexpected ciphertext beat %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (m_tdata[63:0] !== want[63:0])
                    begin
                        $error("ciphertext_low: expected %h, got %h", want[63:0], m_tdata[63:0]);
                        mismatches++;
                    end
                    if (m_tdata[127:64] !== want[127:64])
                    begin
                        $error("ciphertext_high: expected %h, got %h",
                               want[127:64], m_tdata[127:64]);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (plain_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (cipher_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_key(input logic idx, input logic [63:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    initial
    begin
        logic [127:0] blk;
        logic [63:0]  klo;
        logic [63:0]  khi;
        int           pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // key still at its reset value of zero
        plain_q.push_back(128'h0);
        plain_q.push_back(~128'h0);
        plain_q.push_back(128'h1);
        plain_q.push_back(128'h1 << 127);
        plain_q.push_back({64'h0, ~64'h0});
        plain_q.push_back({~64'h0, 64'h0});
        plain_q.push_back({4{32'h5555_5555}});
        plain_q.push_back({4{32'haaaa_aaaa}});
        plain_q.push_back({2{32'h8000_0000, 32'h0000_0001}});
        plain_q.push_back({2{32'h0000_0001, 32'h8000_0000}});
        wait_idle();

        ready_mode <= ReadyRandom;
        max_gap    <= 3;
        write_key(RegKeyLow, ~64'h0);
        write_key(RegKeyHigh, ~64'h0);
        plain_q.push_back(128'h0);
        plain_q.push_back(~128'h0);
        plain_q.push_back({4{32'h5555_5555}});
        plain_q.push_back({4{32'haaaa_aaaa}});
        plain_q.push_back({32'hcccc_dddd, 32'haaaa_bbbb, 32'h4444_5555, 32'h2222_3333});
        wait_idle();

        write_key(RegKeyLow, 64'h0);
        plain_q.push_back(128'h0);
        plain_q.push_back(~128'h0);
        plain_q.push_back({32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210});
        wait_idle();

        write_key(RegKeyLow, ~64'h0);
        write_key(RegKeyHigh, 64'h0);
        plain_q.push_back(128'h0);
        plain_q.push_back(~128'h0);
        plain_q.push_back(128'h1 << 64);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            ready_mode <= ready_mode_t'(ph % 3);
            max_gap    <= (ph % 4 == 0) ? 0 : ((ph % 4 == 1) ? 4 : 16);
            klo = {$urandom, $urandom};
            khi = {$urandom, $urandom};
            // now and then an extreme key
            if (ph == 3)
                klo = 64'h0;
            if (ph == 5)
                khi = ~64'h0;
            write_key(RegKeyLow, klo);
            write_key(RegKeyHigh, khi);
            for (int n = 0; n < 200; n++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0)
                        blk[32*i +: 32] = 32'h0;
                    else if (pick == 1)
                        blk[32*i +: 32] = 32'hffff_ffff;
                    else
                        blk[32*i +: 32] = $urandom;
                end
                plain_q.push_back(blk);
            end
            wait_idle();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("cham128_block_encrypt_unit verification clean");
        else
            $display("cham128_block_encrypt_unit verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("cham128_block_encrypt_unit verification failed");
        $finish;
    end

endmodule
